/* hdl/ata_pio_pkg.sv */
package ata_pio_pkg;

  localparam int unsigned WORDS_PER_SECTOR = 256;
  localparam int unsigned WIDX_W           = $clog2(WORDS_PER_SECTOR);
  localparam int unsigned MAX_RES          = 6;
  localparam int unsigned CNT_W            = $clog2(MAX_RES + 1);

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned LBA_W    = 28;
  localparam int unsigned SECT_W   = 8;
  localparam int unsigned BUDGET_W = 20;
  localparam int unsigned CFG_W    = 20;

  // Command block register offsets
  localparam logic [ADDR_W-1:0] OFS_DATA   = 16'd0;
  localparam logic [ADDR_W-1:0] OFS_COUNT  = 16'd2;
  localparam logic [ADDR_W-1:0] OFS_LBA_LO = 16'd3;
  localparam logic [ADDR_W-1:0] OFS_LBA_MD = 16'd4;
  localparam logic [ADDR_W-1:0] OFS_LBA_HI = 16'd5;
  localparam logic [ADDR_W-1:0] OFS_DRVHD  = 16'd6;
  localparam logic [ADDR_W-1:0] OFS_CMD    = 16'd7;

  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_FLUSH = 8'hE7;

  localparam int unsigned ST_BSY_BIT = 7;
  localparam int unsigned ST_DRQ_BIT = 3;
  localparam int unsigned ST_ERR_BIT = 0;

  localparam logic [ADDR_W-1:0]   RST_IO_BASE   = 16'd496;
  localparam logic [ADDR_W-1:0]   RST_CTRL_BASE = 16'd1014;
  localparam logic [7:0]          RST_DRV_SEL   = 8'd224;
  localparam logic [BUDGET_W-1:0] RST_BUDGET    = 20'd100000;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_STATUS = 2'd1,
    REQ_DATA   = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ACT_WR_BYTE = 3'd0,
    ACT_POLL    = 3'd1,
    ACT_RD_WORD = 3'd2,
    ACT_WR_WORD = 3'd3,
    ACT_DELAY   = 3'd4,
    ACT_DELIVER = 3'd5,
    ACT_DONE    = 3'd6,
    ACT_ERROR   = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_BSY_PRE   = 3'd1,
    CAUSE_BSY_SEC   = 3'd2,
    CAUSE_DRQ       = 3'd3,
    CAUSE_ERR       = 3'd4,
    CAUSE_BSY_FLUSH = 3'd5
  } cause_e;

  typedef enum logic [1:0] {
    CFG_IO_BASE   = 2'd0,
    CFG_CTRL_BASE = 2'd1,
    CFG_DRV_SEL   = 2'd2,
    CFG_BUDGET    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ADDR_W-1:0]   io_base;
    logic [ADDR_W-1:0]   ctrl_base;
    logic [7:0]          drv_sel;
    logic [BUDGET_W-1:0] budget;
  } cfg_t;

  typedef struct packed {
    action_e           action;
    logic [ADDR_W-1:0] port_addr;
    logic [VAL_W-1:0]  value;
    cause_e            cause;
  } res_t;

  function automatic res_t mk_res(action_e act, logic [ADDR_W-1:0] port,
                                  logic [VAL_W-1:0] val, cause_e cause);
    res_t r;
    r.action    = act;
    r.port_addr = port;
    r.value     = val;
    r.cause     = cause;
    return r;
  endfunction

endpackage

/* hdl/ata_pio_seq.sv */
module ata_pio_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic [1:0]                        req_i,
  input  logic                              is_write_i,
  input  logic [ata_pio_pkg::LBA_W-1:0]     lba_i,
  input  logic [ata_pio_pkg::SECT_W-1:0]    sector_total_i,
  input  logic [7:0]                        status_i,
  input  logic [ata_pio_pkg::VAL_W-1:0]     word_i,
  input  ata_pio_pkg::cfg_t                 cfg_i,
  output logic [ata_pio_pkg::CNT_W-1:0]     n_o,
  output ata_pio_pkg::res_t                 res_o [ata_pio_pkg::MAX_RES]
);

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_BSY_PRE   = 8'b0000_0010,
    PH_BSY_SEC   = 8'b0000_0100,
    PH_DRQ       = 8'b0000_1000,
    PH_CHK_ERR   = 8'b0001_0000,
    PH_RD_DATA   = 8'b0010_0000,
    PH_WR_DATA   = 8'b0100_0000,
    PH_BSY_FLUSH = 8'b1000_0000
  } phase_e;

  phase_e                             phase_q, phase_d;
  logic [ata_pio_pkg::BUDGET_W-1:0]   polls_q, polls_d;
  logic [ata_pio_pkg::LBA_W-1:0]      lba_q, lba_d;
  logic [ata_pio_pkg::SECT_W-1:0]     sect_q, sect_d;
  logic [ata_pio_pkg::WIDX_W-1:0]     widx_q, widx_d;
  logic                               dir_q, dir_d;

  ata_pio_pkg::res_t                  poll_res, done_res, end_res;
  logic [ata_pio_pkg::SECT_W-1:0]     sect_dec;
  phase_e                             end_phase;
  logic                               word_last, in_wait, met;
  ata_pio_pkg::cause_e                fail_cause;
  logic [ata_pio_pkg::ADDR_W-1:0]     addr_cmd;

  assign addr_cmd  = cfg_i.io_base + ata_pio_pkg::OFS_CMD;
  assign poll_res  = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_POLL, addr_cmd, '0,
                                         ata_pio_pkg::CAUSE_NONE);
  assign done_res  = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_DONE, '0, '0,
                                         ata_pio_pkg::CAUSE_NONE);
  assign word_last = (widx_q == ata_pio_pkg::WIDX_W'(ata_pio_pkg::WORDS_PER_SECTOR - 1));

  // End of sector: count down, then either finish or wait for the next sector
  assign sect_dec  = sect_q - 1'b1;
  assign end_res   = (sect_dec == '0) ? done_res : poll_res;
  assign end_phase = (sect_dec == '0) ? PH_IDLE : PH_BSY_SEC;

  assign in_wait = (phase_q == PH_BSY_PRE) || (phase_q == PH_BSY_SEC) ||
                   (phase_q == PH_DRQ) || (phase_q == PH_BSY_FLUSH);
  assign met     = (phase_q == PH_DRQ) ? status_i[ata_pio_pkg::ST_DRQ_BIT]
                                       : !status_i[ata_pio_pkg::ST_BSY_BIT];

  always_comb begin
    case (phase_q)
      PH_BSY_PRE: fail_cause = ata_pio_pkg::CAUSE_BSY_PRE;
      PH_BSY_SEC: fail_cause = ata_pio_pkg::CAUSE_BSY_SEC;
      PH_DRQ:     fail_cause = ata_pio_pkg::CAUSE_DRQ;
      default:    fail_cause = ata_pio_pkg::CAUSE_BSY_FLUSH;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    polls_d = polls_q;
    lba_d   = lba_q;
    sect_d  = sect_q;
    widx_d  = widx_q;
    dir_d   = dir_q;
    n_o     = '0;
    for (int i = 0; i < ata_pio_pkg::MAX_RES; i++) begin
      res_o[i] = '0;
    end

    case (ata_pio_pkg::req_e'(req_i))
      ata_pio_pkg::REQ_START: begin
        if (phase_q == PH_IDLE) begin
          dir_d    = is_write_i;
          lba_d    = lba_i;
          sect_d   = sector_total_i;
          widx_d   = '0;
          res_o[0] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_WR_BYTE,
                       cfg_i.io_base + ata_pio_pkg::OFS_DRVHD,
                       {8'd0, cfg_i.drv_sel | {4'd0, lba_i[27:24]}},
                       ata_pio_pkg::CAUSE_NONE);
          res_o[1] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_DELAY, cfg_i.ctrl_base, '0,
                                         ata_pio_pkg::CAUSE_NONE);
          res_o[2] = poll_res;
          phase_d  = PH_BSY_PRE;
          polls_d  = cfg_i.budget;
          n_o      = 3'd3;
        end
      end
      ata_pio_pkg::REQ_STATUS: begin
        if (in_wait) begin
          n_o = 3'd1;
          if (met && (polls_q != '0)) begin
            case (phase_q)
              PH_BSY_PRE: begin
                res_o[0] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_WR_BYTE,
                             cfg_i.io_base + ata_pio_pkg::OFS_COUNT, {8'd0, sect_q},
                             ata_pio_pkg::CAUSE_NONE);
                res_o[1] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_WR_BYTE,
                             cfg_i.io_base + ata_pio_pkg::OFS_LBA_LO, {8'd0, lba_q[7:0]},
                             ata_pio_pkg::CAUSE_NONE);
                res_o[2] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_WR_BYTE,
                             cfg_i.io_base + ata_pio_pkg::OFS_LBA_MD, {8'd0, lba_q[15:8]},
                             ata_pio_pkg::CAUSE_NONE);
                res_o[3] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_WR_BYTE,
                             cfg_i.io_base + ata_pio_pkg::OFS_LBA_HI, {8'd0, lba_q[23:16]},
                             ata_pio_pkg::CAUSE_NONE);
                res_o[4] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_WR_BYTE, addr_cmd,
                             {8'd0, dir_q ? ata_pio_pkg::CMD_WRITE : ata_pio_pkg::CMD_READ},
                             ata_pio_pkg::CAUSE_NONE);
                n_o = 3'd6;
                // zero count: command goes out and the transfer completes at once
                if (sect_q == '0) begin
                  res_o[5] = done_res;
                  phase_d  = PH_IDLE;
                end else begin
                  res_o[5] = poll_res;
                  phase_d  = PH_BSY_SEC;
                  polls_d  = cfg_i.budget;
                end
              end
              PH_BSY_SEC: begin
                res_o[0] = poll_res;
                phase_d  = PH_DRQ;
                polls_d  = cfg_i.budget;
              end
              PH_DRQ: begin
                res_o[0] = poll_res;
                phase_d  = PH_CHK_ERR;
              end
              default: begin
                widx_d   = '0;
                sect_d   = sect_dec;
                res_o[0] = end_res;
                phase_d  = end_phase;
                polls_d  = cfg_i.budget;
              end
            endcase
          end else if (polls_q == '0) begin
            res_o[0] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_ERROR, '0, '0, fail_cause);
            phase_d  = PH_IDLE;
          end else begin
            polls_d  = polls_q - 1'b1;
            res_o[0] = poll_res;
          end
        end else if (phase_q == PH_CHK_ERR) begin
          widx_d = '0;
          if (status_i[ata_pio_pkg::ST_ERR_BIT]) begin
            res_o[0] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_ERROR, '0, '0,
                                           ata_pio_pkg::CAUSE_ERR);
            phase_d  = PH_IDLE;
            n_o      = 3'd1;
          end else if (dir_q) begin
            phase_d = PH_WR_DATA;
          end else begin
            res_o[0] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_RD_WORD,
                         cfg_i.io_base + ata_pio_pkg::OFS_DATA, '0, ata_pio_pkg::CAUSE_NONE);
            phase_d  = PH_RD_DATA;
            n_o      = 3'd1;
          end
        end
      end
      ata_pio_pkg::REQ_DATA: begin
        if (phase_q == PH_RD_DATA) begin
          res_o[0] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_DELIVER, '0, word_i,
                                         ata_pio_pkg::CAUSE_NONE);
          n_o      = 3'd2;
          if (word_last) begin
            widx_d   = '0;
            sect_d   = sect_dec;
            res_o[1] = end_res;
            phase_d  = end_phase;
            polls_d  = cfg_i.budget;
          end else begin
            widx_d   = widx_q + 1'b1;
            res_o[1] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_RD_WORD,
                         cfg_i.io_base + ata_pio_pkg::OFS_DATA, '0, ata_pio_pkg::CAUSE_NONE);
          end
        end else if (phase_q == PH_WR_DATA) begin
          res_o[0] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_WR_WORD,
                       cfg_i.io_base + ata_pio_pkg::OFS_DATA, word_i, ata_pio_pkg::CAUSE_NONE);
          if (word_last) begin
            widx_d   = '0;
            res_o[1] = ata_pio_pkg::mk_res(ata_pio_pkg::ACT_WR_BYTE, addr_cmd,
                         {8'd0, ata_pio_pkg::CMD_FLUSH}, ata_pio_pkg::CAUSE_NONE);
            res_o[2] = poll_res;
            phase_d  = PH_BSY_FLUSH;
            polls_d  = cfg_i.budget;
            n_o      = 3'd3;
          end else begin
            widx_d = widx_q + 1'b1;
            n_o    = 3'd1;
          end
        end
      end
      default: begin
      end
    endcase

    if (!fire_i) begin
      n_o = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      polls_q <= '0;
      lba_q   <= '0;
      sect_q  <= '0;
      widx_q  <= '0;
      dir_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      polls_q <= polls_d;
      lba_q   <= lba_d;
      sect_q  <= sect_d;
      widx_q  <= widx_d;
      dir_q   <= dir_d;
    end
  end

endmodule

/* hdl/ata_pio_obuf.sv */
module ata_pio_obuf (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [ata_pio_pkg::CNT_W-1:0]  n_i,
  input  ata_pio_pkg::res_t              res_i [ata_pio_pkg::MAX_RES],
  input  logic                           take_ready_i,
  output logic                           space_o,
  output logic                           valid_o,
  output logic                           last_o,
  output ata_pio_pkg::res_t              head_o
);

  ata_pio_pkg::res_t               ent_q [ata_pio_pkg::MAX_RES];
  logic [ata_pio_pkg::CNT_W-1:0]   cnt_q;
  logic                            take, do_load;

  assign valid_o = (cnt_q != '0);
  assign last_o  = (cnt_q == ata_pio_pkg::CNT_W'(1));
  assign head_o  = ent_q[0];
  assign take    = valid_o && take_ready_i;
  // Room for a new burst once the buffer is empty or its final result leaves now
  assign space_o = !valid_o || (last_o && take_ready_i);
  assign do_load = load_i && (n_i != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (do_load) begin
      cnt_q <= n_i;
    end else if (take) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      ent_q <= res_i;
    end else if (take) begin
      for (int i = 0; i < ata_pio_pkg::MAX_RES - 1; i++) begin
        ent_q[i] <= ent_q[i+1];
      end
      ent_q[ata_pio_pkg::MAX_RES-1] <= ent_q[ata_pio_pkg::MAX_RES-1];
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ata_pio_pkg::CNT_W'(ata_pio_pkg::MAX_RES))
    else $error("result count out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_load |-> space_o)
    else $error("burst loaded over pending results");

  a_drain_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !do_load) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("result count did not advance on transfer");

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_load |=> cnt_q == $past(n_i))
    else $error("burst count not loaded");

endmodule

/* hdl/ata_pio_sector_transfer_engine_top.sv */
// ATA PIO LBA28 host sequencer.
// Input stream (s_axis): one request per transfer. tuser selects the kind:
// start (direction, LBA, sector count), a status byte answering the last
// poll, or a data word (read from the drive, or to be written to it).
// Output stream (m_axis): bus actions for the host adapter (write byte,
// poll status, read/write word, 400 ns delay) plus deliver word, done and
// error. tuser carries the action, tlast marks the final result of a request.
// Configuration: cfg_we_i writes register cfg_idx_i (0 io_base, 1 ctrl_base,
// 2 drive select byte, 3 poll budget) with cfg_data_i; write only while idle.
// The first result of a request appears the cycle after its transfer.
// Each request yields 0 to 6 results, one per cycle while m_axis_tready
// is high. A new request is taken in the same cycle the final result of
// the previous one leaves, so requests with at most one result stream at
// one per cycle while the output is not stalled. The result buffer holds
// one burst at a time, which sets that figure.
// Reset: registers return to their defaults and the engine goes idle.
// Output stall: results hold while m_axis_tready is low; s_axis_tready stays
// low until the pending burst is down to its last result being taken.
module ata_pio_sector_transfer_engine_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // cfg register write port
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [ata_pio_pkg::CFG_W-1:0]       cfg_data_i,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: is_write[0], lba[28:1], sector_total[36:29],
  //        status_byte[44:37], data_word[60:45], zero fill [63:61]
  input  logic [63:0]                         s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]                          s_axis_tuser,
  // action stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: port_addr[15:0], value[31:16], error_cause[34:32], zero fill [39:35]
  output logic [39:0]                         m_axis_tdata,
  // tuser: action[2:0]
  output logic [2:0]                          m_axis_tuser,
  output logic                                m_axis_tlast
);

  ata_pio_pkg::cfg_t                cfg_q;
  logic                             fire;
  logic [ata_pio_pkg::CNT_W-1:0]    n;
  ata_pio_pkg::res_t                res [ata_pio_pkg::MAX_RES];
  ata_pio_pkg::res_t                head;

  // Hold the configuration; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.io_base   <= ata_pio_pkg::RST_IO_BASE;
      cfg_q.ctrl_base <= ata_pio_pkg::RST_CTRL_BASE;
      cfg_q.drv_sel   <= ata_pio_pkg::RST_DRV_SEL;
      cfg_q.budget    <= ata_pio_pkg::RST_BUDGET;
    end else if (cfg_we_i) begin
      case (ata_pio_pkg::cfg_idx_e'(cfg_idx_i))
        ata_pio_pkg::CFG_IO_BASE:   cfg_q.io_base   <= cfg_data_i[15:0];
        ata_pio_pkg::CFG_CTRL_BASE: cfg_q.ctrl_base <= cfg_data_i[15:0];
        ata_pio_pkg::CFG_DRV_SEL:   cfg_q.drv_sel   <= cfg_data_i[7:0];
        ata_pio_pkg::CFG_BUDGET:    cfg_q.budget    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign fire = s_axis_tvalid && s_axis_tready;

  // Decode the request against the phase and build its burst of results
  ata_pio_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .req_i          (s_axis_tuser),
    .is_write_i     (s_axis_tdata[0]),
    .lba_i          (s_axis_tdata[28:1]),
    .sector_total_i (s_axis_tdata[36:29]),
    .status_i       (s_axis_tdata[44:37]),
    .word_i         (s_axis_tdata[60:45]),
    .cfg_i          (cfg_q),
    .n_o            (n),
    .res_o          (res)
  );

  // Register the burst and drain it one result per transfer
  ata_pio_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (fire),
    .n_i          (n),
    .res_i        (res),
    .take_ready_i (m_axis_tready),
    .space_o      (s_axis_tready),
    .valid_o      (m_axis_tvalid),
    .last_o       (m_axis_tlast),
    .head_o       (head)
  );

  assign m_axis_tuser = head.action;
  assign m_axis_tdata = {5'd0, head.cause, head.value, head.port_addr};

endmodule
